FILE: rtl/ata_pio_sector_read_sequencer_core_assert.svh
// Assertion macros used by the sector read sequencer checker.
`ifndef ATA_PIO_SECTOR_READ_SEQUENCER_CORE_ASSERT_SVH
`define ATA_PIO_SECTOR_READ_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define ATA_PSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ata_psr: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define ATA_PSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ata_psr: next-cycle check failed");

`endif

FILE: rtl/ata_psr_pkg.sv
// Shared types and constants of the ATA PIO sector read sequencer.
`timescale 1ns / 1ps

package ata_psr_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_STATUS = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_t;

    // Result operation codes.
    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_POLL  = 3'd1,
        OP_REQ   = 3'd2,
        OP_DATA  = 3'd3,
        OP_OK    = 3'd4,
        OP_FAIL  = 3'd5
    } op_t;

    // Configuration register indexes.
    localparam logic REG_LBA48_MODE   = 1'b0;
    localparam logic REG_FINAL_CHECK  = 1'b1;

    // Status register bit positions.
    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    // Task-file register offsets.
    localparam logic [2:0] TF_COUNT   = 3'd2;
    localparam logic [2:0] TF_LBA_LO  = 3'd3;
    localparam logic [2:0] TF_LBA_MID = 3'd4;
    localparam logic [2:0] TF_LBA_HI  = 3'd5;
    localparam logic [2:0] TF_DEVICE  = 3'd6;
    localparam logic [2:0] TF_COMMAND = 3'd7;

    // Command opcodes and device bytes.
    localparam logic [7:0] ATA_READ_SECTORS     = 8'h21;
    localparam logic [7:0] ATA_READ_SECTORS_EXT = 8'h24;
    localparam logic [7:0] DEV_LBA28            = 8'hE0;
    localparam logic [7:0] DEV_LBA48            = 8'h40;

    // Number of job entries between the front and back halves.
    localparam int QUEUE_DEPTH = 4;

    // Work the back half has to turn into result requests.
    typedef enum logic [3:0] {
        J_POLL,
        J_REQ,
        J_OK,
        J_FAIL,
        J_DATA,
        J_DATA_POLL,
        J_DATA_OK,
        J_BURST28,
        J_BURST48
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] word;   // latched LBA for bursts, sector data for data jobs
        logic [6:0]  idx;    // word index for data jobs
    } job_t;

    typedef struct packed {
        logic lba48;
        logic final_check;
    } cfg_t;

endpackage

FILE: rtl/ata_psr_queue.sv
// Short job queue that decouples the front and back halves.
`timescale 1ns / 1ps

module ata_psr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ata_psr_pkg::job_t  push_job,
    input  logic               pop,
    output ata_psr_pkg::job_t  head,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = $clog2(ata_psr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ata_psr_pkg::QUEUE_DEPTH + 1);

    ata_psr_pkg::job_t slot_reg [ata_psr_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(ata_psr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ata_psr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ata_psr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/ata_psr_front.sv
// Front half: accepts requests, runs the read phase machine and queues jobs.
`timescale 1ns / 1ps

module ata_psr_front #(
    parameter int SECTOR_WORDS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ata_psr_pkg::cfg_t  cfg,
    input  logic               accept,
    input  logic [1:0]         command,
    input  logic [31:0]        lba,
    input  logic [7:0]         status_byte,
    input  logic [31:0]        data_in,
    output logic               push,
    output ata_psr_pkg::job_t  push_job
);

    localparam int CNT_W = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READY,
        PH_CMD,
        PH_DRQ,
        PH_DATA,
        PH_FINAL
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        lba_reg, lba_next;
    logic               bsy;
    logic               drq;
    logic               err;
    logic               last_word;

    assign bsy       = status_byte[ata_psr_pkg::ST_BSY_BIT];
    assign drq       = status_byte[ata_psr_pkg::ST_DRQ_BIT];
    assign err       = status_byte[ata_psr_pkg::ST_ERR_BIT];
    assign last_word = (cnt_reg == CNT_W'(SECTOR_WORDS - 1));

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        lba_next      = lba_reg;
        push          = 1'b0;
        push_job.kind = ata_psr_pkg::J_POLL;
        push_job.word = '0;
        push_job.idx  = '0;
        if (accept)
        begin
            unique case (command)
                ata_psr_pkg::CMD_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        lba_next   = lba;
                        push       = 1'b1;
                        phase_next = PH_READY;
                    end
                end
                ata_psr_pkg::CMD_STATUS:
                begin
                    unique case (phase_reg)
                        PH_READY:
                        begin
                            push = 1'b1;
                            if (!bsy)
                            begin
                                push_job.kind = cfg.lba48 ? ata_psr_pkg::J_BURST48 :
                                                            ata_psr_pkg::J_BURST28;
                                push_job.word = lba_reg;
                                phase_next    = PH_CMD;
                            end
                        end
                        PH_CMD:
                        begin
                            push = 1'b1;
                            if (!bsy)
                            begin
                                if (err)
                                begin
                                    push_job.kind = ata_psr_pkg::J_FAIL;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_DRQ;
                                end
                            end
                        end
                        PH_DRQ:
                        begin
                            push = 1'b1;
                            if (drq)
                            begin
                                push_job.kind = ata_psr_pkg::J_REQ;
                                cnt_next      = '0;
                                phase_next    = PH_DATA;
                            end
                        end
                        PH_FINAL:
                        begin
                            push          = 1'b1;
                            push_job.kind = err ? ata_psr_pkg::J_FAIL : ata_psr_pkg::J_OK;
                            phase_next    = PH_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ata_psr_pkg::CMD_DATA:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        push          = 1'b1;
                        push_job.word = data_in;
                        push_job.idx  = 7'(cnt_reg);
                        push_job.kind = ata_psr_pkg::J_DATA;
                        if (last_word)
                        begin
                            cnt_next = '0;
                            if (cfg.final_check)
                            begin
                                push_job.kind = ata_psr_pkg::J_DATA_POLL;
                                phase_next    = PH_FINAL;
                            end
                            else
                            begin
                                push_job.kind = ata_psr_pkg::J_DATA_OK;
                                phase_next    = PH_IDLE;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            lba_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            lba_reg   <= lba_next;
        end
    end

endmodule

FILE: rtl/ata_psr_back.sv
// Back half: expands queued jobs into result requests behind an output register.
`timescale 1ns / 1ps

module ata_psr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ata_psr_pkg::job_t  head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         operation,
    output logic [2:0]         register_offset,
    output logic [7:0]         register_value,
    output logic [31:0]        data_out,
    output logic [6:0]         word_index,
    output logic               last
);

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  reg_off;
        logic [7:0]  reg_val;
        logic [31:0] data;
        logic [6:0]  idx;
        logic        last;
    } result_t;

    logic        valid_reg, valid_next;
    logic [3:0]  step_reg, step_next;
    result_t     res;
    result_t     res_reg;
    logic        out_free;
    logic        emit;
    logic [31:0] a;

    assign out_free = !valid_reg || !out_stall;
    assign emit     = out_free && !empty;
    assign pop      = emit && res.last;
    assign a        = head.word;

    // Result for the current step of the job at the head of the queue.
    always_comb
    begin
        res      = '0;
        res.op   = ata_psr_pkg::OP_WRITE;
        unique case (head.kind)
            ata_psr_pkg::J_POLL:
            begin
                res.op   = ata_psr_pkg::OP_POLL;
                res.last = 1'b1;
            end
            ata_psr_pkg::J_REQ:
            begin
                res.op   = ata_psr_pkg::OP_REQ;
                res.last = 1'b1;
            end
            ata_psr_pkg::J_OK:
            begin
                res.op   = ata_psr_pkg::OP_OK;
                res.last = 1'b1;
            end
            ata_psr_pkg::J_FAIL:
            begin
                res.op   = ata_psr_pkg::OP_FAIL;
                res.last = 1'b1;
            end
            ata_psr_pkg::J_DATA:
            begin
                res.op   = ata_psr_pkg::OP_DATA;
                res.data = head.word;
                res.idx  = head.idx;
                res.last = 1'b1;
            end
            ata_psr_pkg::J_DATA_POLL, ata_psr_pkg::J_DATA_OK:
            begin
                if (step_reg == 4'd0)
                begin
                    res.op   = ata_psr_pkg::OP_DATA;
                    res.data = head.word;
                    res.idx  = head.idx;
                end
                else
                begin
                    res.op   = (head.kind == ata_psr_pkg::J_DATA_POLL) ?
                               ata_psr_pkg::OP_POLL : ata_psr_pkg::OP_OK;
                    res.last = 1'b1;
                end
            end
            ata_psr_pkg::J_BURST28:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        res.reg_off = ata_psr_pkg::TF_DEVICE;
                        res.reg_val = ata_psr_pkg::DEV_LBA28 | {4'h0, a[27:24]};
                    end
                    4'd1:
                    begin
                        res.reg_off = ata_psr_pkg::TF_COUNT;
                        res.reg_val = 8'd1;
                    end
                    4'd2:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_LO;
                        res.reg_val = a[7:0];
                    end
                    4'd3:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_MID;
                        res.reg_val = a[15:8];
                    end
                    4'd4:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_HI;
                        res.reg_val = a[23:16];
                    end
                    4'd5:
                    begin
                        res.reg_off = ata_psr_pkg::TF_COMMAND;
                        res.reg_val = ata_psr_pkg::ATA_READ_SECTORS;
                    end
                    default:
                    begin
                        res.op   = ata_psr_pkg::OP_POLL;
                        res.last = 1'b1;
                    end
                endcase
            end
            ata_psr_pkg::J_BURST48:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        res.reg_off = ata_psr_pkg::TF_DEVICE;
                        res.reg_val = ata_psr_pkg::DEV_LBA48;
                    end
                    4'd1:
                    begin
                        res.reg_off = ata_psr_pkg::TF_COUNT;
                    end
                    4'd2:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_LO;
                        res.reg_val = a[31:24];
                    end
                    4'd3:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_MID;
                    end
                    4'd4:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_HI;
                    end
                    4'd5:
                    begin
                        res.reg_off = ata_psr_pkg::TF_COUNT;
                        res.reg_val = 8'd1;
                    end
                    4'd6:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_LO;
                        res.reg_val = a[7:0];
                    end
                    4'd7:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_MID;
                        res.reg_val = a[15:8];
                    end
                    4'd8:
                    begin
                        res.reg_off = ata_psr_pkg::TF_LBA_HI;
                        res.reg_val = a[23:16];
                    end
                    4'd9:
                    begin
                        res.reg_off = ata_psr_pkg::TF_COMMAND;
                        res.reg_val = ata_psr_pkg::ATA_READ_SECTORS_EXT;
                    end
                    default:
                    begin
                        res.op   = ata_psr_pkg::OP_POLL;
                        res.last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                res.op   = ata_psr_pkg::OP_POLL;
                res.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            step_next  = res.last ? 4'd0 : step_reg + 4'd1;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = valid_reg;
    assign operation       = res_reg.op;
    assign register_offset = res_reg.reg_off;
    assign register_value  = res_reg.reg_val;
    assign data_out        = res_reg.data;
    assign word_index      = res_reg.idx;
    assign last            = res_reg.last;

endmodule

FILE: rtl/ata_pio_sector_read_sequencer_core.sv
// Top level of the host-side ATA PIO single-sector read sequencer.
`timescale 1ns / 1ps

// This block drives one ATA PIO sector read, LBA28 or LBA48, from the host side.
// A start request latches the LBA and asks for a status poll; status bytes and
// data dwords returned by the drive move it through the busy wait, the task-file
// register burst, the DRQ wait and the data phase, and each accepted request
// yields zero or more result requests, the last one flagged by last. The input
// side takes one request per clock whenever the job queue has room: the front
// half decides what a request causes in the cycle it is accepted and pushes at most
// one job into a four-entry queue. The back half drains that queue and presents one
// result per clock while out_stall is low, through an output register. One result
// comes from a single-result request, seven from the register burst after busy
// clears in LBA28 mode and eleven in LBA48 mode, and two from the last data dword.
// The first result of a request passes through the job queue and then the output
// register before it reaches the output ports. in_stall rises only when the queue
// is full, which happens when the consumer stalls or bursts pile up. lba48_mode
// and final_status_check are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while no read is in flight, as the block does not
// enforce it. They reset to LBA28 and to final status check enabled. Requests that
// do not fit the current phase, and command code 3, are accepted and cause nothing.
module ata_pio_sector_read_sequencer_core #(
    parameter int SECTOR_WORDS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    // Input request channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] lba,
    input  logic [7:0]  status_byte,
    input  logic [31:0] data_in,
    // Result request channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  operation,
    output logic [2:0]  register_offset,
    output logic [7:0]  register_value,
    output logic [31:0] data_out,
    output logic [6:0]  word_index,
    output logic        last
);

    ata_psr_pkg::cfg_t cfg_reg;
    ata_psr_pkg::job_t push_job;
    ata_psr_pkg::job_t head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              accept;

    // The front half never needs more than one queue slot per request, so a
    // full queue is the only reason to hold off the producer.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Configuration registers; only bit 0 of the data is meaningful.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lba48       <= 1'b0;
            cfg_reg.final_check <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ata_psr_pkg::REG_LBA48_MODE:  cfg_reg.lba48       <= cfg_data;
                ata_psr_pkg::REG_FINAL_CHECK: cfg_reg.final_check <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ata_psr_front #(
        .SECTOR_WORDS (SECTOR_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .command     (command),
        .lba         (lba),
        .status_byte (status_byte),
        .data_in     (data_in),
        .push        (push),
        .push_job    (push_job)
    );

    ata_psr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ata_psr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (q_empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .operation       (operation),
        .register_offset (register_offset),
        .register_value  (register_value),
        .data_out        (data_out),
        .word_index      (word_index),
        .last            (last)
    );

endmodule

FILE: rtl/ata_psr_checker.sv
// Port-level checker for the sector read sequencer and its bind.
`timescale 1ns / 1ps
`include "ata_pio_sector_read_sequencer_core_assert.svh"

module ata_psr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  operation,
    input logic [2:0]  register_offset,
    input logic [7:0]  register_value,
    input logic [31:0] data_out,
    input logic [6:0]  word_index,
    input logic        last
);

    // A stalled result request holds its operation and last flag.
    `ATA_PSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(operation) && $stable(last))

    // Only the six defined operations ever leave the block.
    `ATA_PSR_ASSERT_NOW(a_op_range, out_valid, operation <= ata_psr_pkg::OP_FAIL)

    // Register fields are zero unless the result is a task-file write.
    `ATA_PSR_ASSERT_NOW(a_reg_zero, out_valid && operation != ata_psr_pkg::OP_WRITE,
        register_offset == 3'd0 && register_value == 8'd0)

    // Data fields are zero unless the result is a data word.
    `ATA_PSR_ASSERT_NOW(a_data_zero, out_valid && operation != ata_psr_pkg::OP_DATA,
        data_out == 32'd0 && word_index == 7'd0)

endmodule

bind ata_pio_sector_read_sequencer_core ata_psr_checker u_psr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .operation       (operation),
    .register_offset (register_offset),
    .register_value  (register_value),
    .data_out        (data_out),
    .word_index      (word_index),
    .last            (last)
);

FILE: bench/ata_pio_sector_read_sequencer_core_test.sv
// Self-checking bench for the ATA PIO sector read sequencer: predicted results, random traffic.
`timescale 1ns / 1ps

// The bench drives the block through whole sector reads in both LBA28 and LBA48
// mode, with and without the closing status check. It also drives reads that end
// early on a command error, and it mixes in requests that the block must ignore.
// Every accepted request is handed to a tracker. The tracker keeps its own copy of
// the sequencer state and the two settings, and it queues the result requests that
// the block owes. Every accepted result request is checked field by field against
// the oldest queued one.
// Both channels idle at random. Most gaps are short, a few are long, and some reads
// run with no gaps at all. During one read the consumer holds off for a long
// stretch, so the job queue fills up and the block must hold off the sender.
// A watchdog ends the run when nothing moves on either channel for too long.
module ata_pio_sector_read_sequencer_core_test;

    localparam int SECTOR_WORDS = 128;

    // Command code 3 has no meaning; the block must accept it and do nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Reads keep starting until this many requests have been sent in total.
    localparam int REQUEST_TARGET  = 420;
    localparam int NOISE_PCT       = 8;
    localparam int HOLD_CYCLES     = 300;
    // An ignored request produces no result and pushes no job. Once the last result
    // has arrived, the bench still lets a settling time pass before it writes a setting.
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 40;

    // Phases of one sector read as the host side sees them.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_WAIT_READY,
        SEQ_WAIT_CMD,
        SEQ_WAIT_DRQ,
        SEQ_DATA,
        SEQ_FINAL
    } seq_phase_t;

    // One result request as the block should present it.
    typedef struct {
        ata_psr_pkg::op_t op;
        logic [2:0]       offset;
        logic [7:0]       value;
        logic [31:0]      word;
        logic [6:0]       idx;
        logic             last;
    } sector_result_t;

    // Tracks the read sequence and holds the result requests still owed by the block.
    class read_sequence_tracker;
        seq_phase_t     phase;
        int unsigned    words_seen;
        logic [31:0]    held_lba;
        logic           lba48;
        logic           final_check;
        sector_result_t awaited_results[$];
        int unsigned    mismatches;
        int unsigned    results_seen;
        int unsigned    sectors_read;
        int unsigned    failed_reads;

        function new();
            phase        = SEQ_IDLE;
            words_seen   = 0;
            held_lba     = '0;
            lba48        = 1'b0;
            final_check  = 1'b1;
            mismatches   = 0;
            results_seen = 0;
            sectors_read = 0;
            failed_reads = 0;
        endfunction

        function void set_register(logic idx, logic val);
            if (idx == ata_psr_pkg::REG_LBA48_MODE)
                lba48 = val;
            else
                final_check = val;
        endfunction

        function void add(ata_psr_pkg::op_t op, logic [2:0] offset = '0,
                          logic [7:0] value = '0, logic [31:0] word = '0,
                          logic [6:0] idx = '0);
            sector_result_t r;
            r.op     = op;
            r.offset = offset;
            r.value  = value;
            r.word   = word;
            r.idx    = idx;
            r.last   = 1'b0;
            awaited_results.push_back(r);
        endfunction

        // Advances the sequence by one accepted request and queues what it causes.
        function int take_request(logic [1:0] cmd, logic [31:0] addr, logic [7:0] st,
                                  logic [31:0] word);
            int before_count;
            before_count = awaited_results.size();
            case (cmd)
                ata_psr_pkg::CMD_START:
                begin
                    if (phase == SEQ_IDLE)
                    begin
                        held_lba = addr;
                        add(ata_psr_pkg::OP_POLL);
                        phase = SEQ_WAIT_READY;
                    end
                end
                ata_psr_pkg::CMD_STATUS:
                begin
                    case (phase)
                        SEQ_WAIT_READY:
                        begin
                            if (st[ata_psr_pkg::ST_BSY_BIT])
                                add(ata_psr_pkg::OP_POLL);
                            else
                            begin
                                if (!lba48)
                                begin
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_DEVICE,
                                        ata_psr_pkg::DEV_LBA28 | {4'h0, held_lba[27:24]});
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_COUNT, 8'd1);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_LO,
                                        held_lba[7:0]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_MID,
                                        held_lba[15:8]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_HI,
                                        held_lba[23:16]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_COMMAND,
                                        ata_psr_pkg::ATA_READ_SECTORS);
                                end
                                else
                                begin
                                    // High-order bytes go first, then the low-order ones.
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_DEVICE,
                                        ata_psr_pkg::DEV_LBA48);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_COUNT, 8'd0);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_LO,
                                        held_lba[31:24]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_MID, 8'd0);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_HI, 8'd0);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_COUNT, 8'd1);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_LO,
                                        held_lba[7:0]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_MID,
                                        held_lba[15:8]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_LBA_HI,
                                        held_lba[23:16]);
                                    add(ata_psr_pkg::OP_WRITE, ata_psr_pkg::TF_COMMAND,
                                        ata_psr_pkg::ATA_READ_SECTORS_EXT);
                                end
                                add(ata_psr_pkg::OP_POLL);
                                phase = SEQ_WAIT_CMD;
                            end
                        end
                        SEQ_WAIT_CMD:
                        begin
                            if (st[ata_psr_pkg::ST_BSY_BIT])
                                add(ata_psr_pkg::OP_POLL);
                            else if (st[ata_psr_pkg::ST_ERR_BIT])
                            begin
                                add(ata_psr_pkg::OP_FAIL);
                                failed_reads++;
                                phase = SEQ_IDLE;
                            end
                            else
                            begin
                                add(ata_psr_pkg::OP_POLL);
                                phase = SEQ_WAIT_DRQ;
                            end
                        end
                        SEQ_WAIT_DRQ:
                        begin
                            if (st[ata_psr_pkg::ST_DRQ_BIT])
                            begin
                                add(ata_psr_pkg::OP_REQ);
                                words_seen = 0;
                                phase = SEQ_DATA;
                            end
                            else
                                add(ata_psr_pkg::OP_POLL);
                        end
                        SEQ_FINAL:
                        begin
                            if (st[ata_psr_pkg::ST_ERR_BIT])
                            begin
                                add(ata_psr_pkg::OP_FAIL);
                                failed_reads++;
                            end
                            else
                                add(ata_psr_pkg::OP_OK);
                            phase = SEQ_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ata_psr_pkg::CMD_DATA:
                begin
                    if (phase == SEQ_DATA)
                    begin
                        add(ata_psr_pkg::OP_DATA, 3'd0, 8'd0, word, words_seen[6:0]);
                        words_seen++;
                        if (words_seen >= SECTOR_WORDS)
                        begin
                            words_seen = 0;
                            sectors_read++;
                            if (final_check)
                            begin
                                add(ata_psr_pkg::OP_POLL);
                                phase = SEQ_FINAL;
                            end
                            else
                            begin
                                add(ata_psr_pkg::OP_OK);
                                phase = SEQ_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (awaited_results.size() > before_count)
                awaited_results[awaited_results.size() - 1].last = 1'b1;
            return awaited_results.size() - before_count;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        function void check_result(logic [2:0] op, logic [2:0] offset, logic [7:0] value,
                                   logic [31:0] word, logic [6:0] idx, logic fin);
            sector_result_t head;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $error("operation: expected no result, got 0x%0h", op);
                return;
            end
            head = awaited_results.pop_front();
            compare("operation", 32'(head.op), 32'(op));
            compare("register_offset", 32'(head.offset), 32'(offset));
            compare("register_value", 32'(head.value), 32'(value));
            compare("data_out", head.word, word);
            compare("word_index", 32'(head.idx), 32'(idx));
            compare("last", 32'(head.last), 32'(fin));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [31:0] lba;
    logic [7:0]  status_byte;
    logic [31:0] data_in;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  operation;
    logic [2:0]  register_offset;
    logic [7:0]  register_value;
    logic [31:0] data_out;
    logic [6:0]  word_index;
    logic        last;

    read_sequence_tracker tracker = new();

    // Quiet flags switch off the random gaps on one side. The main process counts
    // hold-off requests in hold_requests, and the consumer process starts one long
    // hold-off for each new one.
    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned hold_requests;
    int unsigned requests_sent;
    int unsigned productive_requests;
    int unsigned input_stall_cycles = 0;
    int          idle_cycles = 0;

    ata_pio_sector_read_sequencer_core #(
        .SECTOR_WORDS(SECTOR_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .lba(lba),
        .status_byte(status_byte),
        .data_in(data_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .operation(operation),
        .register_offset(register_offset),
        .register_value(register_value),
        .data_out(data_out),
        .word_index(word_index),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sender gap before a request. Most gaps are zero or short, a few are long.
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (tx_quiet || r < 65)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // Mostly random addresses, with the extremes mixed in. The extremes include the
    // nibble that LBA28 folds into the device byte and the byte that only LBA48 sends.
    function automatic logic [31:0] pick_lba();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0FFF_FFFF;
            3: return 32'hF000_0000;
            default: return 32'($urandom);
        endcase
    endfunction

    // Offers one request and waits until the block takes it. The task returns at the
    // accepting edge with in_valid still high, so the next request can follow directly.
    task automatic send(input logic [1:0] cmd, input logic [31:0] addr, input logic [7:0] st,
                        input logic [31:0] word);
        int gap;
        int produced;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        lba         <= addr;
        status_byte <= st;
        data_in     <= word;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        produced = tracker.take_request(cmd, addr, st, word);
        requests_sent++;
        if (produced > 0)
            productive_requests++;
    endtask

    // Sometimes sends a request that does not fit the current phase. The block
    // must take such a request and produce no result for it.
    task automatic maybe_noise();
        int pick;
        if ($urandom_range(0, 99) >= NOISE_PCT)
            return;
        pick = int'($urandom_range(0, 2));
        if (pick == 1 && tracker.phase != SEQ_IDLE)
            send(ata_psr_pkg::CMD_START, 32'($urandom), 8'($urandom), 32'($urandom));
        else if (pick == 2 && tracker.phase != SEQ_DATA)
            send(ata_psr_pkg::CMD_DATA, 32'($urandom), 8'($urandom), 32'($urandom));
        else if (pick == 2)
            send(ata_psr_pkg::CMD_STATUS, 32'($urandom), 8'($urandom), 32'($urandom));
        else
            send(CMD_UNUSED, 32'($urandom), 8'($urandom), 32'($urandom));
    endtask

    // Writes one setting once the block has drained and sits idle.
    task automatic write_setting(input logic idx, input logic val);
        in_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_register(idx, val);
        cfg_we <= 1'b0;
    endtask

    // Feeds data dwords until the sector is complete, with stray requests in between.
    task automatic stream_sector();
        while (tracker.phase == SEQ_DATA)
        begin
            maybe_noise();
            send(ata_psr_pkg::CMD_DATA, 32'($urandom), 8'($urandom), 32'($urandom));
        end
    endtask

    // One read from start to finish, with random status contents and random numbers
    // of busy and DRQ polls. Unless whole is set, some reads end on a command error.
    // When squeeze is set, the consumer holds off during the data phase.
    task automatic run_read(input bit whole, input bit squeeze);
        logic [7:0] st;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if (squeeze)
        begin
            tx_quiet = 1'b1;
            rx_quiet = 1'b0;
        end
        maybe_noise();
        send(ata_psr_pkg::CMD_START, pick_lba(), 8'($urandom), 32'($urandom));
        repeat ($urandom_range(0, 3))
        begin
            st = 8'($urandom);
            st[ata_psr_pkg::ST_BSY_BIT] = 1'b1;
            maybe_noise();
            send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
        end
        // The drive is ready, so the task-file burst goes out.
        st = 8'($urandom);
        st[ata_psr_pkg::ST_BSY_BIT] = 1'b0;
        send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
        repeat ($urandom_range(0, 2))
        begin
            st = 8'($urandom);
            st[ata_psr_pkg::ST_BSY_BIT] = 1'b1;
            maybe_noise();
            send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
        end
        if (!whole && $urandom_range(0, 99) < 35)
        begin
            st = 8'($urandom);
            st[ata_psr_pkg::ST_BSY_BIT] = 1'b0;
            st[ata_psr_pkg::ST_ERR_BIT] = 1'b1;
            send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
            return;
        end
        st = 8'($urandom);
        st[ata_psr_pkg::ST_BSY_BIT] = 1'b0;
        st[ata_psr_pkg::ST_ERR_BIT] = 1'b0;
        send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
        repeat ($urandom_range(0, 3))
        begin
            st = 8'($urandom);
            st[ata_psr_pkg::ST_DRQ_BIT] = 1'b0;
            maybe_noise();
            send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
        end
        st = 8'($urandom);
        st[ata_psr_pkg::ST_DRQ_BIT] = 1'b1;
        send(ata_psr_pkg::CMD_STATUS, 32'($urandom), st, 32'($urandom));
        if (squeeze)
            hold_requests++;
        stream_sector();
        if (tracker.phase == SEQ_FINAL)
        begin
            maybe_noise();
            send(ata_psr_pkg::CMD_STATUS, 32'($urandom), 8'($urandom), 32'($urandom));
        end
        tx_quiet = 1'b0;
    endtask

    // Consumer side. It stalls in random runs, stays open while rx_quiet is set, and
    // gives one long hold-off for each new request from the main process.
    initial
    begin
        int hold_left;
        int run_left;
        bit run_stalls;
        int unsigned holds_taken;
        hold_left   = 0;
        run_left    = 0;
        run_stalls  = 1'b0;
        holds_taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_taken)
            begin
                holds_taken = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else if (run_left > 0)
            begin
                run_left--;
                out_stall <= run_stalls;
            end
            else
            begin
                run_stalls = ($urandom_range(0, 99) < 35);
                if ($urandom_range(0, 9) == 0)
                    run_left = int'($urandom_range(15, 40));
                else
                    run_left = int'($urandom_range(1, 4));
                out_stall <= run_stalls;
            end
        end
    end

    // Result monitor. Values are sampled at the edge, before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.check_result(operation, register_offset, register_value, data_out,
                                 word_index, last);
    end

    // Watchdog. It counts the cycles in which neither channel moves. It also counts
    // the cycles in which the block holds off the sender.
    always @(posedge clk)
    begin
        if (in_valid === 1'b1 && in_stall === 1'b1)
            input_stall_cycles <= input_stall_cycles + 1;
        if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0)
                || (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int reads;
        tx_quiet            = 1'b0;
        rx_quiet            = 1'b0;
        hold_requests       = 0;
        requests_sent       = 0;
        productive_requests = 0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= ata_psr_pkg::REG_LBA48_MODE;
        cfg_data    <= 1'b0;
        in_valid    <= 1'b0;
        command     <= ata_psr_pkg::CMD_START;
        lba         <= '0;
        status_byte <= '0;
        data_in     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The block starts at the reset settings, LBA28 with the closing
        // status check. The first three requests do not fit the idle phase: a status
        // byte, a data dword, and the unused command code.
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'hFF, 32'h0);
        send(ata_psr_pkg::CMD_DATA, 32'h0, 8'h00, 32'hFFFF_FFFF);
        send(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send(ata_psr_pkg::CMD_START, 32'hFFFF_FFFF, 8'h00, 32'h0);
        // A second start while a read is running is ignored. The first address is kept.
        send(ata_psr_pkg::CMD_START, 32'h0, 8'h00, 32'h0);
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'hFF, 32'h0);
        send(ata_psr_pkg::CMD_DATA, 32'h0, 8'h00, 32'h1234_5678);
        // BSY is clear here and every other status bit is set. The LBA28 burst carries
        // the all-ones address.
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h7F, 32'h0);
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h80, 32'h0);
        // After the command, ERR set with BSY clear ends the read in error even with DRQ up.
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h09, 32'h0);

        write_setting(ata_psr_pkg::REG_LBA48_MODE, 1'b1);
        send(ata_psr_pkg::CMD_START, 32'h0, 8'h00, 32'h0);
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h00, 32'h0);
        // A clean status after the command only leads to a new poll. The DRQ bit it
        // carries does not count.
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h08, 32'h0);
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'hF7, 32'h0);
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h08, 32'h0);
        // A status byte and a start during the data phase are both ignored.
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'hFF, 32'h0);
        send(ata_psr_pkg::CMD_START, 32'hFFFF_FFFF, 8'h00, 32'h0);
        send(ata_psr_pkg::CMD_DATA, 32'h0, 8'h00, 32'hFFFF_FFFF);
        send(ata_psr_pkg::CMD_DATA, 32'h0, 8'h00, 32'h0000_0000);
        stream_sector();
        // ERR in the closing status check turns a complete sector into an error.
        send(ata_psr_pkg::CMD_STATUS, 32'h0, 8'h01, 32'h0);

        // Random part. The first read runs in LBA48 mode without the closing check, and
        // the consumer holds off during its data phase. The second read runs in LBA28
        // mode with the check. After that, reads and settings are random.
        reads = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            if (reads == 0)
            begin
                write_setting(ata_psr_pkg::REG_FINAL_CHECK, 1'b0);
                run_read(1'b1, 1'b1);
            end
            else if (reads == 1)
            begin
                write_setting(ata_psr_pkg::REG_LBA48_MODE, 1'b0);
                write_setting(ata_psr_pkg::REG_FINAL_CHECK, 1'b1);
                run_read(1'b1, 1'b0);
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    write_setting(ata_psr_pkg::REG_LBA48_MODE, 1'($urandom_range(0, 1)));
                    write_setting(ata_psr_pkg::REG_FINAL_CHECK, 1'($urandom_range(0, 1)));
                end
                run_read(1'b0, 1'b0);
            end
            reads++;
        end

        in_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests, %0d of them with results, and checked %0d results.",
                 requests_sent, productive_requests, tracker.results_seen);
        $display("Sectors transferred: %0d, reads ended in error: %0d, input held off: %0d cycles.",
                 tracker.sectors_read, tracker.failed_reads, input_stall_cycles);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
